// ===== hw/rtl/afc_pkg.sv =====
// Package for the AABB frustum culling block: shared widths, plane register
// field positions and the pipeline control struct.
// No dependencies; used by every module of the block.
package afc_pkg;

	// Fixed field widths.
	localparam int TAG_W      = 16;
	localparam int CNT_W      = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	// Plane register packing: three Q1.12 normal components and a Q21.0 offset.
	localparam int NRM_W   = 14;
	localparam int OFS_W   = 22;
	localparam int NX_LSB  = 0;
	localparam int NY_LSB  = 14;
	localparam int NZ_LSB  = 28;
	localparam int OFS_LSB = 42;

	// The offset is scaled by 2^12 to line up with the normal fraction bits.
	localparam int OFS_SHIFT = 12;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	// Load enables for the pipeline stages behind the input register.
	typedef struct packed {
		logic adv_s2;
		logic adv_s3;
		logic adv_s4;
	} pipe_ctl_t;

endpackage

// ===== hw/rtl/afc_plane_eval.sv =====
// Per-plane box test: products, partial sums and the final sign check,
// one register rank after each step.
// Depends on afc_pkg.
module afc_plane_eval #(
	parameter int COORD_BITS = 20
) (
	input  logic                               clk,
	input  afc_pkg::pipe_ctl_t                 ctl,
	input  logic [afc_pkg::CFG_DATA_W-1:0]     plane,
	input  logic signed [COORD_BITS-1:0]       cx,
	input  logic signed [COORD_BITS-1:0]       cy,
	input  logic signed [COORD_BITS-1:0]       cz,
	input  logic [COORD_BITS-2:0]              ex,
	input  logic [COORD_BITS-2:0]              ey,
	input  logic [COORD_BITS-2:0]              ez,
	output logic                               outside
);
	import afc_pkg::*;

	localparam int PC_W   = COORD_BITS + NRM_W;
	localparam int PE_W   = COORD_BITS + NRM_W - 1;
	localparam int OT_W   = OFS_W + OFS_SHIFT;
	localparam int DIST_W = ((PC_W > OT_W) ? PC_W : OT_W) + 2;
	localparam int RAD_W  = PE_W + 2;
	localparam int TOT_W  = DIST_W + 1;

	logic [NRM_W-1:0] n_raw [3];
	logic [NRM_W-1:0] n_abs [3];
	logic signed [COORD_BITS-1:0] c_in [3];
	logic [COORD_BITS-2:0] e_in [3];

	logic signed [PC_W-1:0] pc_s2 [3];
	logic [PE_W-1:0] pe_s2 [3];
	logic [OFS_W-1:0] ofs_s2;

	logic signed [DIST_W-1:0] dist_s3;
	logic [RAD_W-1:0] rad_s3;
	logic outside_s4;

	logic signed [DIST_W-1:0] dist_sum;
	logic [RAD_W-1:0] rad_sum;
	logic [TOT_W-1:0] tot_sum;

	// Unpack the normal and take magnitudes.
	always_comb begin
		n_raw[0] = plane[NX_LSB +: NRM_W];
		n_raw[1] = plane[NY_LSB +: NRM_W];
		n_raw[2] = plane[NZ_LSB +: NRM_W];
		c_in[0] = cx;
		c_in[1] = cy;
		c_in[2] = cz;
		e_in[0] = ex;
		e_in[1] = ey;
		e_in[2] = ez;
		for (int k = 0; k < 3; k++) begin
			n_abs[k] = n_raw[k][NRM_W-1] ? (~n_raw[k] + NRM_W'(1)) : n_raw[k];
		end
	end

	// Stage 2: one multiplier per term.
	always_ff @(posedge clk) begin
		if (ctl.adv_s2) begin
			for (int k = 0; k < 3; k++) begin
				pc_s2[k] <= $signed(n_raw[k]) * c_in[k];
				pe_s2[k] <= n_abs[k] * e_in[k];
			end
			ofs_s2 <= plane[OFS_LSB +: OFS_W];
		end
	end

	// Partial sums: signed distance and projected radius.
	always_comb begin
		dist_sum = $signed({{(DIST_W-OT_W){ofs_s2[OFS_W-1]}}, ofs_s2, {OFS_SHIFT{1'b0}}});
		rad_sum  = '0;
		for (int k = 0; k < 3; k++) begin
			dist_sum = dist_sum + $signed({{(DIST_W-PC_W){pc_s2[k][PC_W-1]}}, pc_s2[k]});
			rad_sum  = rad_sum + {{(RAD_W-PE_W){1'b0}}, pe_s2[k]};
		end
	end

	// Stage 3: register the two sums.
	always_ff @(posedge clk) begin
		if (ctl.adv_s3) begin
			dist_s3 <= dist_sum;
			rad_s3  <= rad_sum;
		end
	end

	// The box is behind this plane when distance plus radius is negative.
	assign tot_sum = {dist_s3[DIST_W-1], dist_s3} + {{(TOT_W-RAD_W){1'b0}}, rad_s3};

	// Stage 4: register the verdict.
	always_ff @(posedge clk) begin
		if (ctl.adv_s4) begin
			outside_s4 <= tot_sum[TOT_W-1];
		end
	end

	assign outside = outside_s4;

endmodule

// ===== hw/rtl/afc_count.sv =====
// Result stage: merges the per-plane verdicts, keeps the saturating frame
// counts and holds the output word. Depends on afc_pkg.
module afc_count #(
	parameter int NUM_PLANES = 6
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         load,
	input  logic                         new_frame,
	input  logic [afc_pkg::TAG_W-1:0]    tag,
	input  logic [NUM_PLANES-1:0]        outside,
	output logic [afc_pkg::TAG_W-1:0]    tag_out,
	output logic                         is_culled,
	output logic [afc_pkg::CNT_W-1:0]    tested_total,
	output logic [afc_pkg::CNT_W-1:0]    culled_total,
	output logic [afc_pkg::CNT_W-1:0]    visible_total
);
	import afc_pkg::*;

	logic [TAG_W-1:0] tag_q;
	logic culled_q;
	logic [CNT_W-1:0] tested_q, culled_cnt_q, visible_q;
	logic [CNT_W-1:0] tested_base, culled_base, visible_base;
	logic [CNT_W-1:0] tested_nxt, culled_nxt, visible_nxt;
	logic hit;

	// Culled by any plane; counts restart on a new frame before this box.
	always_comb begin
		hit = |outside;
		tested_base  = new_frame ? '0 : tested_q;
		culled_base  = new_frame ? '0 : culled_cnt_q;
		visible_base = new_frame ? '0 : visible_q;
		tested_nxt   = (tested_base == CNT_MAX) ? CNT_MAX : tested_base + CNT_W'(1);
		culled_nxt   = culled_base;
		visible_nxt  = visible_base;
		if (hit) begin
			culled_nxt = (culled_base == CNT_MAX) ? CNT_MAX : culled_base + CNT_W'(1);
		end else begin
			visible_nxt = (visible_base == CNT_MAX) ? CNT_MAX : visible_base + CNT_W'(1);
		end
	end

	// Frame counts double as the count fields of the output word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tested_q     <= '0;
			culled_cnt_q <= '0;
			visible_q    <= '0;
		end else if (load) begin
			tested_q     <= tested_nxt;
			culled_cnt_q <= culled_nxt;
			visible_q    <= visible_nxt;
		end
	end

	// Tag and verdict of the word on the output.
	always_ff @(posedge clk) begin
		if (load) begin
			tag_q    <= tag;
			culled_q <= hit;
		end
	end

	assign tag_out       = tag_q;
	assign is_culled     = culled_q;
	assign tested_total  = tested_q;
	assign culled_total  = culled_cnt_q;
	assign visible_total = visible_q;

endmodule

// ===== hw/rtl/aabb_frustum_cull.sv =====
// Top level of the AABB frustum culling block: plane registers, input
// register, stage control and the side pipeline for tag and frame flag.
// Depends on afc_pkg, afc_plane_eval and afc_count.
//
//   channel | signals                            | direction
//   --------+------------------------------------+----------
//   in      | in_valid, in_stall, box fields     | into block
//   out     | out_valid, out_stall, result word  | out of block
//   cfg     | cfg_we, cfg_index, cfg_data        | into block
//
// One word is accepted per cycle while in_stall is low; a result then passes through the input register,
// products, partial sums, plane verdicts and output registers in that order.
// The sustained rate is set by the five-stage pipeline, which holds one word per stage.
// Reset clears all valid flags, the plane registers and the frame counts.
// When out_stall holds a result, stages behind it keep filling bubbles and then stall.
module aabb_frustum_cull #(
	parameter int NUM_PLANES = 6,
	parameter int COORD_BITS = 20
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [afc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [afc_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                new_frame,
	input  logic [afc_pkg::TAG_W-1:0]           entity_tag,
	input  logic signed [COORD_BITS-1:0]        center_x,
	input  logic signed [COORD_BITS-1:0]        center_y,
	input  logic signed [COORD_BITS-1:0]        center_z,
	input  logic [COORD_BITS-2:0]               extent_x,
	input  logic [COORD_BITS-2:0]               extent_y,
	input  logic [COORD_BITS-2:0]               extent_z,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [afc_pkg::TAG_W-1:0]           tag_out,
	output logic                                is_culled,
	output logic [afc_pkg::CNT_W-1:0]           tested_total,
	output logic [afc_pkg::CNT_W-1:0]           culled_total,
	output logic [afc_pkg::CNT_W-1:0]           visible_total
);
	import afc_pkg::*;

	logic [CFG_DATA_W-1:0] plane_q [NUM_PLANES];

	logic v_s1, v_s2, v_s3, v_s4, out_valid_q;
	logic accept, adv_out;
	pipe_ctl_t ctl;

	logic new_frame_s1, new_frame_s2, new_frame_s3, new_frame_s4;
	logic [TAG_W-1:0] tag_s1, tag_s2, tag_s3, tag_s4;
	logic signed [COORD_BITS-1:0] cx_s1, cy_s1, cz_s1;
	logic [COORD_BITS-2:0] ex_s1, ey_s1, ez_s1;
	logic [NUM_PLANES-1:0] outside_s4;

	// Plane registers; indexes past the last plane are ignored.
	for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane_reg
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				plane_q[p] <= '0;
			end else if (cfg_we && (cfg_index == CFG_IDX_W'(p))) begin
				plane_q[p] <= cfg_data;
			end
		end
	end

	// Stage control: a stage loads when its source is full and it is empty or draining.
	always_comb begin
		adv_out    = v_s4 && (!out_valid_q || !out_stall);
		ctl.adv_s4 = v_s3 && (!v_s4 || adv_out);
		ctl.adv_s3 = v_s2 && (!v_s3 || ctl.adv_s4);
		ctl.adv_s2 = v_s1 && (!v_s2 || ctl.adv_s3);
		in_stall   = v_s1 && !ctl.adv_s2;
		accept     = in_valid && !in_stall;
	end

	// Stage valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1        <= accept || (v_s1 && !ctl.adv_s2);
			v_s2        <= ctl.adv_s2 || (v_s2 && !ctl.adv_s3);
			v_s3        <= ctl.adv_s3 || (v_s3 && !ctl.adv_s4);
			v_s4        <= ctl.adv_s4 || (v_s4 && !adv_out);
			out_valid_q <= adv_out || (out_valid_q && out_stall);
		end
	end

	// Input register.
	always_ff @(posedge clk) begin
		if (accept) begin
			new_frame_s1 <= new_frame;
			tag_s1       <= entity_tag;
			cx_s1        <= center_x;
			cy_s1        <= center_y;
			cz_s1        <= center_z;
			ex_s1        <= extent_x;
			ey_s1        <= extent_y;
			ez_s1        <= extent_z;
		end
	end

	// Tag and frame flag follow the word down the pipeline.
	always_ff @(posedge clk) begin
		if (ctl.adv_s2) begin
			new_frame_s2 <= new_frame_s1;
			tag_s2       <= tag_s1;
		end
		if (ctl.adv_s3) begin
			new_frame_s3 <= new_frame_s2;
			tag_s3       <= tag_s2;
		end
		if (ctl.adv_s4) begin
			new_frame_s4 <= new_frame_s3;
			tag_s4       <= tag_s3;
		end
	end

	// One evaluator per plane.
	for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
		afc_plane_eval #(
			.COORD_BITS(COORD_BITS)
		) u_eval (
			.clk     (clk),
			.ctl     (ctl),
			.plane   (plane_q[p]),
			.cx      (cx_s1),
			.cy      (cy_s1),
			.cz      (cz_s1),
			.ex      (ex_s1),
			.ey      (ey_s1),
			.ez      (ez_s1),
			.outside (outside_s4[p])
		);
	end

	// Result stage with the frame counts.
	afc_count #(
		.NUM_PLANES(NUM_PLANES)
	) u_count (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (adv_out),
		.new_frame     (new_frame_s4),
		.tag           (tag_s4),
		.outside       (outside_s4),
		.tag_out       (tag_out),
		.is_culled     (is_culled),
		.tested_total  (tested_total),
		.culled_total  (culled_total),
		.visible_total (visible_total)
	);

	assign out_valid = out_valid_q;

endmodule

// ===== test/tb_aabb_frustum_cull.sv =====
`timescale 1ns / 1ps
// Testbench for aabb_frustum_cull: drives boxes against several plane sets and
// compares every result word with a scoreboard that predicts the culling verdict.
// Depends on afc_pkg and the aabb_frustum_cull RTL.
module tb_aabb_frustum_cull;
	import afc_pkg::*;

	localparam int PLANES          = 6;
	localparam int CB              = 20;
	localparam int EB              = CB - 1;
	localparam int NRM_ONE         = 1 << (NRM_W - 2);
	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int HOLD_CYCLES     = 400;
	localparam int DRAIN_CYCLES    = 10;
	localparam int PHASE_BOXES     = 110;
	localparam int FULL_RATE_BOXES = 80;

	typedef enum logic [CFG_IDX_W-1:0] {
		PL_LEFT, PL_RIGHT, PL_BOTTOM, PL_TOP, PL_NEAR, PL_FAR, PL_SPARE0, PL_SPARE1
	} plane_idx_e;

	typedef logic [CFG_DATA_W-1:0] plane_set_t [PLANES];

	typedef struct {
		logic                 new_frame;
		logic [TAG_W-1:0]     tag;
		logic signed [CB-1:0] c [3];
		logic [EB-1:0]        e [3];
	} box_word_t;

	typedef struct {
		logic [TAG_W-1:0] tag;
		logic             culled;
		logic [CNT_W-1:0] tested;
		logic [CNT_W-1:0] n_culled;
		logic [CNT_W-1:0] n_visible;
	} cull_word_t;

	// Scoreboard: own copy of the planes and frame counts, and the queue of
	// result words still to come.
	class cull_scoreboard;
		logic [CFG_DATA_W-1:0] plane [PLANES];
		logic [CNT_W-1:0]      tested_cnt;
		logic [CNT_W-1:0]      culled_cnt;
		logic [CNT_W-1:0]      visible_cnt;
		cull_word_t            pending [$];
		int                    errors;

		function new();
			foreach (plane[p])
				plane[p] = '0;
			tested_cnt  = '0;
			culled_cnt  = '0;
			visible_cnt = '0;
			errors      = 0;
		endfunction

		function void set_plane(plane_idx_e idx, logic [CFG_DATA_W-1:0] v);
			// Indexes past the far plane have no register behind them.
			if (idx <= PL_FAR)
				plane[idx] = v;
		endfunction

		// A box is culled when it lies wholly on the negative side of any plane.
		function bit box_culled(box_word_t b);
			longint c [3];
			longint e [3];
			int     lsb [3];
			longint n, d, plane_dist, radius;
			lsb[0] = NX_LSB;
			lsb[1] = NY_LSB;
			lsb[2] = NZ_LSB;
			for (int k = 0; k < 3; k++) begin
				c[k] = b.c[k];
				e[k] = b.e[k];
			end
			for (int p = 0; p < PLANES; p++) begin
				d = $signed(plane[p][OFS_LSB +: OFS_W]);
				plane_dist = d * (longint'(1) << OFS_SHIFT);
				radius = 0;
				for (int k = 0; k < 3; k++) begin
					n = $signed(plane[p][lsb[k] +: NRM_W]);
					plane_dist += n * c[k];
					radius += (n < 0 ? -n : n) * e[k];
				end
				if (plane_dist + radius < 0)
					return 1'b1;
			end
			return 1'b0;
		endfunction

		function logic [CNT_W-1:0] bump(logic [CNT_W-1:0] cnt);
			return (cnt == CNT_MAX) ? cnt : cnt + 1'b1;
		endfunction

		// Accepted box: update the frame counts and queue the word it must produce.
		function void note_box(box_word_t b);
			cull_word_t w;
			if (b.new_frame) begin
				tested_cnt  = '0;
				culled_cnt  = '0;
				visible_cnt = '0;
			end
			w.culled = box_culled(b);
			tested_cnt = bump(tested_cnt);
			if (w.culled)
				culled_cnt = bump(culled_cnt);
			else
				visible_cnt = bump(visible_cnt);
			w.tag       = b.tag;
			w.tested    = tested_cnt;
			w.n_culled  = culled_cnt;
			w.n_visible = visible_cnt;
			pending.push_back(w);
		endfunction

		task report(string what);
			$display("%0t ns mismatch: %s", $time, what);
			errors++;
		endtask

		task compare(string field, logic [CNT_W-1:0] got, logic [CNT_W-1:0] want,
			logic [TAG_W-1:0] tag);
			if (got !== want)
				report($sformatf("tag %h: %s is %h, wanted %h", tag, field, got, want));
		endtask

		task check_result(cull_word_t got);
			cull_word_t want;
			if (pending.size() == 0) begin
				report($sformatf("result word with tag %h and no box outstanding", got.tag));
				return;
			end
			want = pending.pop_front();
			compare("tag_out", got.tag, want.tag, want.tag);
			compare("is_culled", {15'd0, got.culled}, {15'd0, want.culled}, want.tag);
			compare("tested_total", got.tested, want.tested, want.tag);
			compare("culled_total", got.n_culled, want.n_culled, want.tag);
			compare("visible_total", got.n_visible, want.n_visible, want.tag);
		endtask
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	logic                  new_frame;
	logic [TAG_W-1:0]      entity_tag;
	logic signed [CB-1:0]  center_x, center_y, center_z;
	logic [EB-1:0]         extent_x, extent_y, extent_z;
	logic                  out_valid;
	logic                  out_stall;
	logic [TAG_W-1:0]      tag_out;
	logic                  is_culled;
	logic [CNT_W-1:0]      tested_total, culled_total, visible_total;

	cull_scoreboard sb = new();

	int tx_gap_max   = 12;
	int burst_left   = 0;
	bit rx_free      = 1'b0;
	int results_seen = 0;
	int idle_cycles  = 0;

	aabb_frustum_cull #(
		.NUM_PLANES(PLANES),
		.COORD_BITS(CB)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.new_frame(new_frame),
		.entity_tag(entity_tag),
		.center_x(center_x),
		.center_y(center_y),
		.center_z(center_z),
		.extent_x(extent_x),
		.extent_y(extent_y),
		.extent_z(extent_z),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.tag_out(tag_out),
		.is_culled(is_culled),
		.tested_total(tested_total),
		.culled_total(culled_total),
		.visible_total(visible_total)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Pack three Q1.12 normal components and a Q21.0 offset into one plane register.
	function automatic logic [CFG_DATA_W-1:0] pack_plane(int nx, int ny, int nz, int d);
		logic [CFG_DATA_W-1:0] r;
		r = '0;
		r[NX_LSB +: NRM_W]  = nx[NRM_W-1:0];
		r[NY_LSB +: NRM_W]  = ny[NRM_W-1:0];
		r[NZ_LSB +: NRM_W]  = nz[NRM_W-1:0];
		r[OFS_LSB +: OFS_W] = d[OFS_W-1:0];
		return r;
	endfunction

	// Axis-aligned cube of half-size lim around the origin, normals facing inward.
	function automatic plane_set_t cube_planes(int lim);
		plane_set_t s;
		s[PL_LEFT]   = pack_plane(NRM_ONE, 0, 0, lim);
		s[PL_RIGHT]  = pack_plane(-NRM_ONE, 0, 0, lim);
		s[PL_BOTTOM] = pack_plane(0, NRM_ONE, 0, lim);
		s[PL_TOP]    = pack_plane(0, -NRM_ONE, 0, lim);
		s[PL_NEAR]   = pack_plane(0, 0, NRM_ONE, lim);
		s[PL_FAR]    = pack_plane(0, 0, -NRM_ONE, lim);
		return s;
	endfunction

	function automatic box_word_t make_box(bit nf, logic [TAG_W-1:0] tag,
		int cx, int cy, int cz, int ex, int ey, int ez);
		box_word_t b;
		b.new_frame = nf;
		b.tag  = tag;
		b.c[0] = cx[CB-1:0];
		b.c[1] = cy[CB-1:0];
		b.c[2] = cz[CB-1:0];
		b.e[0] = ex[EB-1:0];
		b.e[1] = ey[EB-1:0];
		b.e[2] = ez[EB-1:0];
		return b;
	endfunction

	// Random box: either anywhere in the field ranges or near a region of size lim.
	function automatic box_word_t random_box(int lim, bit anywhere);
		box_word_t b;
		int span;
		span = 2 * lim;
		b.new_frame = ($urandom_range(0, 19) == 0);
		b.tag = TAG_W'($urandom_range(0, 65535));
		for (int k = 0; k < 3; k++) begin
			if (anywhere) begin
				b.c[k] = CB'($urandom);
				b.e[k] = EB'($urandom);
			end else begin
				b.c[k] = CB'(int'($urandom_range(0, 2 * span)) - span);
				b.e[k] = EB'($urandom_range(0, lim / 2));
			end
		end
		return b;
	endfunction

	task cfg_write(plane_idx_e idx, logic [CFG_DATA_W-1:0] v);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(posedge clk);
		sb.set_plane(idx, v);
	endtask

	// Write all six planes and one register index that does not exist.
	task load_planes(plane_set_t s);
		for (int p = 0; p < PLANES; p++)
			cfg_write(plane_idx_e'(p), s[p]);
		cfg_write($urandom_range(0, 1) ? PL_SPARE1 : PL_SPARE0, {$urandom, $urandom});
		cfg_we <= 1'b0;
	endtask

	// Stop offering words and wait until every outstanding result has come out.
	task settle();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Offer one box, with a random gap at the start of each burst, and hold it
	// until the block takes it.
	task send_box(box_word_t b);
		int gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 30);
			gap = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
		end
		burst_left--;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		new_frame  <= b.new_frame;
		entity_tag <= b.tag;
		center_x   <= b.c[0];
		center_y   <= b.c[1];
		center_z   <= b.c[2];
		extent_x   <= b.e[0];
		extent_y   <= b.e[1];
		extent_z   <= b.e[2];
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_box(b);
	endtask

	// Receiver: stretches of no stall, random stall and a fixed stall pattern,
	// plus one long hold-off that fills the pipeline.
	initial begin
		bit hold_done;
		int mode, len;
		hold_done = 1'b0;
		out_stall = 1'b0;
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (rx_free) begin
				out_stall <= 1'b0;
				@(posedge clk);
			end else if (!hold_done && results_seen >= 150) begin
				hold_done = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				mode = $urandom_range(0, 2);
				len  = $urandom_range(1, 60);
				for (int i = 0; i < len; i++) begin
					case (mode)
						0: out_stall <= 1'b0;
						1: out_stall <= 1'($urandom_range(0, 1));
						default: out_stall <= (i % 3 == 0);
					endcase
					@(posedge clk);
				end
			end
		end
	end

	// Result monitor.
	always @(posedge clk) begin
		cull_word_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.tag       = tag_out;
			got.culled    = is_culled;
			got.tested    = tested_total;
			got.n_culled  = culled_total;
			got.n_visible = visible_total;
			sb.check_result(got);
			results_seen++;
		end
	end

	// Watchdog: end the run if no word moves on either channel for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin
		plane_set_t set;
		box_word_t  b;
		int         lim, kind;
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		in_valid   = 1'b0;
		new_frame  = 1'b0;
		entity_tag = '0;
		center_x   = '0;
		center_y   = '0;
		center_z   = '0;
		extent_x   = '0;
		extent_y   = '0;
		extent_z   = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Planes at reset are all zero, so nothing may be culled.
		send_box(make_box(1, 16'h0000, -524288, -524288, -524288, 524287, 524287, 524287));
		send_box(make_box(0, 16'hFFFF, 524287, 524287, 524287, 0, 0, 0));
		settle();

		// Cube frustum: boxes touching the left or right side stay visible, one step further out is culled on any side.
		lim = 16000;
		load_planes(cube_planes(lim));
		send_box(make_box(1, 16'h1001, 0, 0, 0, 16, 16, 16));
		send_box(make_box(0, 16'h1002, -lim - 16, 0, 0, 16, 16, 16));
		send_box(make_box(0, 16'h1003, -lim - 17, 0, 0, 16, 16, 16));
		send_box(make_box(0, 16'h1004, lim + 16, 0, 0, 16, 16, 16));
		send_box(make_box(0, 16'h1005, lim + 17, 0, 0, 16, 16, 16));
		send_box(make_box(0, 16'h1006, 0, -lim - 1, 0, 0, 0, 0));
		send_box(make_box(0, 16'h1007, 0, lim + 1, 0, 0, 0, 0));
		send_box(make_box(0, 16'h1008, 0, 0, -lim - 1, 0, 0, 0));
		send_box(make_box(0, 16'h1009, 0, 0, lim + 1, 0, 0, 0));
		send_box(make_box(0, 16'h100A, 300000, -300000, 0, 524287, 524287, 0));
		send_box(make_box(1, 16'h100B, 5, -5, 7, 1, 2, 3));
		settle();

		// Extreme plane registers: all ones, and normals and offsets at their limits.
		set = cube_planes(0);
		set[PL_LEFT]   = '1;
		set[PL_RIGHT]  = pack_plane(-8192, 8191, -8192, 2097151);
		set[PL_BOTTOM] = pack_plane(8191, -8192, 8191, -2097152);
		set[PL_TOP]    = '0;
		set[PL_NEAR]   = pack_plane(-8192, -8192, -8192, -2097152);
		set[PL_FAR]    = '0;
		load_planes(set);
		send_box(make_box(1, 16'h2001, -524288, -524288, -524288, 0, 0, 0));
		send_box(make_box(0, 16'h2002, 524287, 524287, 524287, 524287, 524287, 524287));
		send_box(make_box(0, 16'h2003, 0, 0, 0, 0, 0, 0));
		send_box(make_box(0, 16'h2004, 524287, -524288, 524287, 0, 524287, 0));
		send_box(random_box(0, 1));
		settle();

		// Random phases over a mix of plane sets.
		for (int ph = 0; ph < 5; ph++) begin
			kind = (ph == 0) ? 0 : $urandom_range(0, 3);
			lim = $urandom_range(256, 200000);
			set = cube_planes(lim);
			case (kind)
				1: begin
					foreach (set[p])
						set[p] = {$urandom, $urandom};
				end
				2: begin
					lim = 65536;
					foreach (set[p])
						set[p] = ($urandom_range(0, 3) == 0) ? '0 : pack_plane(
							int'($urandom_range(0, 16383)) - 8192,
							int'($urandom_range(0, 16383)) - 8192,
							int'($urandom_range(0, 16383)) - 8192,
							int'($urandom_range(0, 2 * lim)));
				end
				3: begin
					set[$urandom_range(0, PLANES - 1)] = '0;
					set[$urandom_range(0, PLANES - 1)] = '0;
				end
				default: ;
			endcase
			load_planes(set);
			for (int i = 0; i < PHASE_BOXES; i++)
				send_box(random_box(lim, $urandom_range(0, 9) >= 7));
			settle();
		end

		// Full rate on both sides: words back to back and the receiver never stalls.
		tx_gap_max = 0;
		rx_free = 1'b1;
		lim = 16000;
		load_planes(cube_planes(lim));
		for (int i = 0; i < FULL_RATE_BOXES; i++) begin
			b = random_box(lim, 1'b0);
			send_box(b);
		end

		in_valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
